// File: rtl/core/lbbc_pkg.sv
// Shared types and constants of the LFU byte-budget cache.
package lbbc_pkg;

    localparam int DEF_NUM_KEYS   = 256;
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_COUNT_BITS = 32;

    localparam int KEY_W     = 8;
    localparam int SIZE_W    = 32;
    localparam int ENT_W     = 5;
    localparam int EVC_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITEM_BYTES  = 2'd2;

    localparam logic [ENT_W-1:0]  RST_MAX_ENTRIES = 5'd16;
    localparam logic [SIZE_W-1:0] RST_MAX_BYTES   = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_COUNT,
        ST_CHECK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_slot;
        logic cnt_wr;
        logic scan_start;
        logic scan_step;
        logic evict;
        logic insert;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic admit;
        logic room;
        logic scan_last;
        logic stop;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/lbbc_ctrl.sv
// Request sequencer of the LFU byte-budget cache.
module lbbc_ctrl
    import lbbc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  sts_t   sts,
    output cmd_t   cmd,
    output state_t state
);

    state_t state_reg, state_next;

    assign state = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_READ;
            ST_READ:     state_next = ST_COUNT;
            ST_COUNT:    state_next = (sts.hit || !sts.admit) ? ST_DONE : ST_CHECK;
            ST_CHECK:    state_next = sts.room ? ST_INSERT : ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: state_next = sts.scan_last ? ST_DECIDE : ST_SCAN_RD;
            ST_DECIDE:   state_next = sts.stop ? ST_INSERT : ST_CHECK;
            ST_INSERT:   state_next = ST_DONE;
            ST_DONE:     if (sts.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_COUNT:    cmd.cnt_wr = 1'b1;
            ST_CHECK:    cmd.scan_start = !sts.room;
            ST_SCAN_RD:  cmd.rd_slot = 1'b1;
            ST_SCAN_CMP: cmd.scan_step = 1'b1;
            ST_DECIDE:   cmd.evict = !sts.stop;
            ST_INSERT:   cmd.insert = 1'b1;
            ST_DONE:     cmd.out_load = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/lbbc_dp.sv
// Datapath of the LFU byte-budget cache: use counts, slot table, byte total, result register.
module lbbc_dp
    import lbbc_pkg::*;
#(
    parameter int NUM_KEYS   = DEF_NUM_KEYS,
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int CNT_DEPTH = (NUM_KEYS < 256) ? NUM_KEYS : 256;
    localparam int CIDX_W    = $clog2(CNT_DEPTH);
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW        = $clog2(NUM_SLOTS + 1);
    localparam int LW        = (HW > ENT_W) ? HW : ENT_W;

    // key to count index, folded at elaboration
    logic [CIDX_W-1:0] idx_lut [256];
    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign idx_lut[g] = CIDX_W'(g % NUM_KEYS);
    end

    logic [ENT_W-1:0]  max_entries_reg;
    logic [SIZE_W-1:0] max_total_reg, max_item_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              ok_reg;
    logic              hit_reg;

    logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0]  cnt_vld_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic                  vld_rd_reg;
    logic [COUNT_BITS-1:0] cnt_eff, cnt_inc, in_cnt_reg;
    logic [CIDX_W-1:0]     cnt_addr, key_idx;

    logic [NUM_SLOTS-1:0]  slot_valid_reg;
    logic [KEY_W-1:0]      slot_key_reg  [NUM_SLOTS];
    logic [SIZE_W-1:0]     slot_size_reg [NUM_SLOTS];
    logic [SIZE_W-1:0]     total_reg;
    logic [HW-1:0]         held_reg;

    logic [SLOT_W-1:0]     scan_idx_reg, best_idx_reg, free_idx;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [KEY_W-1:0]      best_key_reg;
    logic                  best_found_reg;

    logic                  inserted_reg;
    logic [EVC_W-1:0]      evicted_reg;

    logic [LW-1:0]  limit;
    logic           bytes_fit, below_limit, hit, better;
    logic [SIZE_W:0] sum;

    assign key_idx  = idx_lut[key_reg];
    assign cnt_addr = cmd.rd_slot ? idx_lut[slot_key_reg[scan_idx_reg]] : key_idx;
    assign cnt_eff  = vld_rd_reg ? cnt_rd_reg : '0;
    assign cnt_inc  = (&cnt_eff) ? cnt_eff : cnt_eff + 1'b1;

    assign limit = (LW'(max_entries_reg) < LW'(NUM_SLOTS)) ? LW'(max_entries_reg)
                                                          : LW'(NUM_SLOTS);
    assign sum         = {1'b0, total_reg} + {1'b0, size_reg};
    assign bytes_fit   = sum <= {1'b0, max_total_reg};
    assign below_limit = LW'(held_reg) < limit;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid_reg[i] && slot_key_reg[i] == key_reg) hit = 1'b1;
        end
    end

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) free_idx = SLOT_W'(i);
        end
    end

    assign better = !best_found_reg || cnt_eff < best_cnt_reg ||
                    (cnt_eff == best_cnt_reg && slot_key_reg[scan_idx_reg] < best_key_reg);

    assign sts.hit       = hit;
    assign sts.admit     = ok_reg && size_reg <= max_item_reg && size_reg <= max_total_reg;
    assign sts.room      = (held_reg == '0) || (below_limit && bytes_fit);
    assign sts.scan_last = scan_idx_reg == SLOT_W'(NUM_SLOTS - 1);
    assign sts.stop      = in_cnt_reg < best_cnt_reg && bytes_fit;
    assign sts.out_free  = !m_tvalid || m_tready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= RST_MAX_ENTRIES;
            max_total_reg   <= RST_MAX_BYTES;
            max_item_reg    <= RST_MAX_BYTES;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_ENTRIES:     max_entries_reg <= cfg_wdata[ENT_W-1:0];
                REG_MAX_TOTAL_BYTES: max_total_reg   <= cfg_wdata;
                REG_MAX_ITEM_BYTES:  max_item_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // use-count memory
    always_ff @(posedge aclk) begin
        cnt_rd_reg <= cnt_mem[cnt_addr];
        if (cmd.cnt_wr) cnt_mem[key_idx] <= cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
            vld_rd_reg  <= 1'b0;
        end else begin
            vld_rd_reg <= cnt_vld_reg[cnt_addr];
            if (cmd.cnt_wr) cnt_vld_reg[key_idx] <= 1'b1;
        end
    end

    // request payload and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            key_reg  <= s_tdata[KEY_W-1:0];
            size_reg <= s_tdata[KEY_W +: SIZE_W];
            ok_reg   <= s_tuser;
        end
        // hold the lookup outcome; the slot table may take the key later
        if (cmd.cnt_wr) begin
            in_cnt_reg <= cnt_inc;
            hit_reg    <= hit;
        end
        if (cmd.scan_step && slot_valid_reg[scan_idx_reg] && better) begin
            best_idx_reg <= scan_idx_reg;
            best_cnt_reg <= cnt_eff;
            best_key_reg <= slot_key_reg[scan_idx_reg];
        end
        if (cmd.insert && below_limit && bytes_fit) begin
            slot_key_reg[free_idx]  <= key_reg;
            slot_size_reg[free_idx] <= size_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            slot_valid_reg <= '0;
            total_reg      <= '0;
            held_reg       <= '0;
            inserted_reg   <= 1'b0;
            evicted_reg    <= '0;
            m_tvalid       <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                inserted_reg <= 1'b0;
                evicted_reg  <= '0;
            end
            if (cmd.scan_start) begin
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (slot_valid_reg[scan_idx_reg]) best_found_reg <= 1'b1;
                if (!sts.scan_last) scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (cmd.evict) begin
                slot_valid_reg[best_idx_reg] <= 1'b0;
                total_reg   <= total_reg - slot_size_reg[best_idx_reg];
                held_reg    <= held_reg - 1'b1;
                evicted_reg <= evicted_reg + 1'b1;
            end
            if (cmd.insert && below_limit && bytes_fit) begin
                slot_valid_reg[free_idx] <= 1'b1;
                total_reg    <= sum[SIZE_W-1:0];
                held_reg     <= held_reg + 1'b1;
                inserted_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata <= {total_reg, evicted_reg, inserted_reg, hit_reg || sts.admit, hit_reg};
        end
    end

endmodule

// File: rtl/core/lfu_byte_budget_cache.sv
// LFU object cache with an entry limit and a byte budget: top level.
//
// One request enters on the s_ channel per transfer: key and item_size in
// s_tdata, fetch_ok in s_tuser. One result leaves on the m_ channel for each.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata); the user
// must write it while no request is in flight, which the block does not enforce.
// Requests are handled one at a time. A hit or a refused miss passes through
// ST_READ and ST_COUNT to ST_DONE; an admitted miss goes on to ST_CHECK and
// may run eviction scan rounds before ST_INSERT, each round visiting every
// slot in ST_SCAN_RD, which reads its use count from the count memory, and
// ST_SCAN_CMP, then deciding in ST_DECIDE.
// The next request is taken in ST_IDLE, right after the result is registered; the
// result register holds while m_tready is low, and a further request is
// processed up to its result, which then waits for the register to free up.
// Reset empties the slot table, clears all use counts at once through
// per-entry valid bits, zeroes the byte total and restores the register
// defaults (16 entries, all-ones byte limits).
module lfu_byte_budget_cache
    import lbbc_pkg::*;
#(
    parameter int NUM_KEYS   = DEF_NUM_KEYS,
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,  // key[7:0], item_size[39:8]
    input  logic [0:0]           s_tuser,  // fetch_ok[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,  // hit, served, inserted, evicted_count[7:3],
                                           // bytes_held[39:8]
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    lbbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    lbbc_dp #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // an inserted miss was served
    a_ins_served: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[2] || m_tdata[1]))
        else $error("inserted result not marked served");

    // a hit neither evicts nor inserts
    a_hit_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (!m_tdata[2] && m_tdata[7:3] == '0))
        else $error("hit changed the slot table");

    // evictions happen only inside the scan loop
    a_evict_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> (state == ST_DECIDE && $past(state) == ST_SCAN_CMP))
        else $error("eviction outside a completed scan");

    // a result is loaded only at the end of a request
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state == ST_IDLE && m_tvalid))
        else $error("result load did not return to idle");

endmodule

// File: sim/lfu_byte_budget_cache_test.sv
// Testbench for the LFU byte-budget cache: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module lfu_byte_budget_cache_test;
    import lbbc_pkg::*;

    localparam int SLOTS = 16;
    localparam int KEYS  = 256;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [31:0] bytes_held;
        logic [4:0]  evicted_count;
        logic        inserted;
        logic        served;
        logic        hit;
    } lookup_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    lfu_byte_budget_cache DUT (.*);

    // predictor state
    logic [31:0] use_count [KEYS];
    logic        held_valid [SLOTS];
    logic [7:0]  held_key [SLOTS];
    logic [31:0] held_size [SLOTS];
    logic [32:0] held_bytes;
    logic [4:0]  entry_limit;
    logic [31:0] byte_budget;
    logic [31:0] item_limit;

    lookup_result_t expected_results[$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    longint cycles = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int occupied();
        int n = 0;
        for (int i = 0; i < SLOTS; i++) if (held_valid[i]) n++;
        return n;
    endfunction

    function automatic lookup_result_t predict_lookup(logic [7:0] key, logic [31:0] size,
                                                      logic ok);
        lookup_result_t r;
        int lim;
        int n;
        int best;
        bit fits;
        int evicted = 0;
        r = '0;
        lim = (entry_limit < SLOTS) ? entry_limit : SLOTS;
        if (use_count[key] != 32'hFFFF_FFFF) use_count[key]++;
        for (int i = 0; i < SLOTS; i++)
            if (held_valid[i] && held_key[i] == key) r.hit = 1'b1;
        if (r.hit) begin
            r.served = 1'b1;
        end else if (ok && size <= item_limit && size <= byte_budget) begin
            r.served = 1'b1;
            forever begin
                n = occupied();
                if (n == 0) break;
                fits = (held_bytes + size) <= {1'b0, byte_budget};
                if (n < lim && fits) break;
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!held_valid[i]) continue;
                    if (best < 0) best = i;
                    else if (use_count[held_key[i]] < use_count[held_key[best]] ||
                             (use_count[held_key[i]] == use_count[held_key[best]] &&
                              held_key[i] < held_key[best])) best = i;
                end
                if (use_count[key] < use_count[held_key[best]] && fits) break;
                held_bytes -= held_size[best];
                held_valid[best] = 1'b0;
                evicted++;
            end
            if (occupied() < lim && (held_bytes + size) <= {1'b0, byte_budget}) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!held_valid[i]) begin
                        held_valid[i] = 1'b1;
                        held_key[i] = key;
                        held_size[i] = size;
                        held_bytes += size;
                        r.inserted = 1'b1;
                        break;
                    end
                end
            end
        end
        r.evicted_count = evicted[4:0];
        r.bytes_held = held_bytes[31:0];
        return r;
    endfunction

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        lookup_result_t got;
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = lookup_result_t'(m_tdata);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.hit !== want.hit || got.served !== want.served ||
                    got.inserted !== want.inserted ||
                    got.evicted_count !== want.evicted_count ||
                    got.bytes_held !== want.bytes_held) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h%0b s%0b i%0b e%0d b%0d, got h%0b s%0b i%0b e%0d b%0d",
                                 want.hit, want.served, want.inserted, want.evicted_count,
                                 want.bytes_held, got.hit, got.served, got.inserted,
                                 got.evicted_count, got.bytes_held);
                end
            end
        end
    end

    // tvalid stays high after a transfer; the next idle cycle or drain drops it
    task automatic send_request(logic [7:0] key, logic [31:0] size, logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {size, key};
        s_tuser <= ok;
        expected_results.push_back(predict_lookup(key, size, ok));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MAX_ENTRIES) entry_limit = value[4:0];
        else if (idx == REG_MAX_TOTAL_BYTES) byte_budget = value;
        else if (idx == REG_MAX_ITEM_BYTES) item_limit = value;
    endtask

    function automatic logic [31:0] rand_size(logic [31:0] scale);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return $urandom_range(scale);
        endcase
    endfunction

    task automatic test_directed();
        send_request(8'd0, 32'd0, 1'b1);
        send_request(8'd255, 32'hFFFF_FFFF, 1'b1);
        send_request(8'd0, 32'd5, 1'b0);
        send_request(8'd7, 32'd10, 1'b0);
        send_request(8'hAA, 32'h5555_5555, 1'b1);
        write_reg(REG_MAX_ENTRIES, 32'd2);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd100);
        write_reg(REG_MAX_ITEM_BYTES, 32'd60);
        send_request(8'd1, 32'd61, 1'b1);
        send_request(8'd2, 32'd101, 1'b1);
        send_request(8'd3, 32'd50, 1'b1);
        send_request(8'd3, 32'd50, 1'b1);
        send_request(8'd4, 32'd50, 1'b1);
        send_request(8'd5, 32'd10, 1'b1);
        send_request(8'd6, 32'd60, 1'b1);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd20);
        send_request(8'd9, 32'd5, 1'b1);
        write_reg(REG_MAX_ENTRIES, 32'd0);
        send_request(8'd10, 32'd1, 1'b1);
        write_reg(REG_MAX_ENTRIES, 32'd31);
        write_reg(REG_MAX_TOTAL_BYTES, 32'hFFFF_FFFF);
        write_reg(REG_MAX_ITEM_BYTES, 32'hFFFF_FFFF);
        for (int k = 20; k < 38; k++) send_request(k[7:0], 32'd1000, 1'b1);
    endtask

    task automatic test_random(int count, int key_span, logic [31:0] scale);
        for (int i = 0; i < count; i++)
            send_request(8'($urandom_range(key_span)), rand_size(scale),
                         $urandom_range(9) != 0);
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge aclk);
                recv_hold = 1'b0;
            end
            begin
                test_random(8, 40, 32'd500);
                s_tvalid <= 1'b0;
            end
        join
    endtask

    task automatic test_settings();
        write_reg(REG_MAX_ENTRIES, 32'd1);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd0);
        write_reg(REG_MAX_ITEM_BYTES, 32'd0);
        test_random(40, 10, 32'd3);
        write_reg(REG_MAX_ENTRIES, 32'd16);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd2000);
        write_reg(REG_MAX_ITEM_BYTES, 32'd700);
        test_random(200, 40, 32'd800);
        write_reg(REG_MAX_ENTRIES, 32'd5);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd300);
        test_random(200, 24, 32'd150);
        write_reg(REG_MAX_ENTRIES, 32'd0);
        test_random(20, 255, 32'd100);
        write_reg(REG_MAX_ENTRIES, 32'd17);
        write_reg(REG_MAX_TOTAL_BYTES, $urandom);
        write_reg(REG_MAX_ITEM_BYTES, $urandom);
        test_random(200, 255, 32'hFFFF_FFFF);
    endtask

    initial begin
        for (int i = 0; i < KEYS; i++) use_count[i] = '0;
        for (int i = 0; i < SLOTS; i++) begin
            held_valid[i] = 1'b0;
            held_key[i] = '0;
            held_size[i] = '0;
        end
        held_bytes = '0;
        entry_limit = RST_MAX_ENTRIES;
        byte_budget = RST_MAX_BYTES;
        item_limit = RST_MAX_BYTES;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        send_idle_pct = 46;
        write_reg(REG_MAX_ENTRIES, 32'd8);
        write_reg(REG_MAX_TOTAL_BYTES, 32'd4000);
        write_reg(REG_MAX_ITEM_BYTES, 32'd1500);
        test_random(200, 30, 32'd1200);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        test_random(200, 30, 32'd1200);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_settings();

        drain();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
